// ===== rtl/core/lru_key_value_cache_macros.svh =====
`ifndef LRU_KEY_VALUE_CACHE_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_MACROS_SVH

// same-cycle implication
`define LKV_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// implication with a delayed consequent
`define LKV_ASSERT_LAT2(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##2 (cons)) else $error(msg);

`endif

// ===== rtl/core/lkv_pkg.sv =====
`default_nettype none

package lkv_pkg;

   localparam int LKV_ENTRIES = 16;
   localparam int KEY_W       = 32;
   localparam int VAL_W       = 32;
   localparam int CAP_W       = 5;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);
   localparam logic [VAL_W-1:0] READ_MISS = '1;

   typedef enum logic {
      OP_GET = 1'b0,
      OP_PUT = 1'b1
   } op_type;

   typedef struct packed {
      logic act;
      logic put;
      logic hit;
      logic clear;
   } entry_ctl_type;

endpackage

`default_nettype wire

// ===== rtl/core/lkv_entry.sv =====
`default_nettype none

module lkv_entry
   import lkv_pkg::*;
#(
   parameter int AGE_W = 4
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire entry_ctl_type       ctl,
   input  wire logic                sel_hit,
   input  wire logic                sel_ins,
   input  wire logic [AGE_W-1:0]    hit_age,
   input  wire logic [KEY_W-1:0]    key_in,
   input  wire logic [VAL_W-1:0]    value_in,
   output logic                     match,
   output logic                     valid,
   output logic [AGE_W-1:0]         age,
   output logic [KEY_W-1:0]         key,
   output logic [VAL_W-1:0]         value
);

   logic             valid_ff, valid_in;
   logic [AGE_W-1:0] age_ff, age_in;
   logic [KEY_W-1:0] key_ff;
   logic [VAL_W-1:0] value_ff;
   logic             ins_here;
   logic             val_wr;

   assign ins_here = ctl.act && ctl.put && !ctl.hit && sel_ins;
   assign val_wr   = ins_here || (ctl.act && ctl.put && ctl.hit && sel_hit);

   always_comb begin
      valid_in = valid_ff;
      age_in   = age_ff;
      if (ctl.clear) begin
         valid_in = 1'b0;
         age_in   = '0;
      end else if (ctl.act && ctl.hit) begin
         if (sel_hit) begin
            age_in = '0;
         end else if (valid_ff && (age_ff < hit_age)) begin
            age_in = age_ff + 1'b1;
         end
      end else if (ctl.act && ctl.put) begin
         if (sel_ins) begin
            valid_in = 1'b1;
            age_in   = '0;
         end else if (valid_ff) begin
            age_in = age_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         age_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         age_ff   <= age_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ins_here) begin
         key_ff <= key_in;
      end
      if (val_wr) begin
         value_ff <= value_in;
      end
   end

   assign match = valid_ff && (key_ff == key_in);
   assign valid = valid_ff;
   assign age   = age_ff;
   assign key   = key_ff;
   assign value = value_ff;

endmodule

`default_nettype wire

// ===== rtl/core/lkv_pick.sv =====
`default_nettype none

module lkv_pick
   import lkv_pkg::*;
#(
   parameter int ENTRIES = LKV_ENTRIES,
   parameter int AGE_W   = 4
) (
   input  wire logic [ENTRIES-1:0] match,
   input  wire logic [ENTRIES-1:0] valid,
   input  wire logic [AGE_W-1:0]   ages   [ENTRIES],
   input  wire logic [KEY_W-1:0]   keys   [ENTRIES],
   input  wire logic [VAL_W-1:0]   values [ENTRIES],
   input  wire logic [AGE_W-1:0]   oldest_age,
   input  wire logic               full,
   output logic                    hit,
   output logic [AGE_W-1:0]        hit_age,
   output logic [VAL_W-1:0]        hit_value,
   output logic [ENTRIES-1:0]      ins_oh,
   output logic [KEY_W-1:0]        victim_key
);

   logic [ENTRIES-1:0] victim_oh;
   logic [ENTRIES-1:0] free_vec;
   logic [ENTRIES-1:0] free_oh;

   assign free_vec = ~valid;
   assign free_oh  = free_vec & (~free_vec + 1'b1);
   assign hit      = |match;
   assign ins_oh   = full ? victim_oh : free_oh;

   always_comb begin
      hit_age    = '0;
      hit_value  = '0;
      victim_key = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         victim_oh[i] = valid[i] && (ages[i] == oldest_age);
         hit_age      = hit_age | (ages[i] & {AGE_W{match[i]}});
         hit_value    = hit_value | (values[i] & {VAL_W{match[i]}});
         victim_key   = victim_key | (keys[i] & {KEY_W{victim_oh[i]}});
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/lru_key_value_cache.sv =====
`default_nettype none

// lru_key_value_cache: fully associative key/value store, lru replacement
//
// request: start with req_opcode (get/put), req_lookup_key, req_store_value;
//    a transaction is taken at a clock edge with start high and busy low.
//    busy is high only during reset, so one transaction per cycle.
// response: rsp_strobe marks one cycle with rsp_found, rsp_read_value,
//    rsp_evicted and rsp_evicted_key; the receiver cannot stall, so
//    every result is consumed in its strobe cycle.
// path: a transaction passes the input register, then one pass of key
//    compare, age update and the result register; throughput is one
//    transaction per cycle, as the compare and age update over all
//    entries are done in one pass.
// csr: csr_valid/csr_ready write csr_capacity; csr_ready is always high.
//    any write empties the store. capacity 0 acts as 1, values above
//    ENTRIES act as ENTRIES. write only while no transaction is in flight.
// reset: store empty, capacity 16, no response pending.

module lru_key_value_cache
   import lkv_pkg::*;
#(
   parameter int ENTRIES = LKV_ENTRIES
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   output logic                         busy,
   input  wire logic                    req_opcode,
   input  wire logic signed [KEY_W-1:0] req_lookup_key,
   input  wire logic signed [VAL_W-1:0] req_store_value,
   output logic                         rsp_strobe,
   output logic                         rsp_found,
   output logic signed [VAL_W-1:0]      rsp_read_value,
   output logic                         rsp_evicted,
   output logic signed [KEY_W-1:0]      rsp_evicted_key,
   input  wire logic                    csr_valid,
   output logic                         csr_ready,
   input  wire logic [CAP_W-1:0]        csr_capacity
);

   localparam int AGE_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int OCC_W = $clog2(ENTRIES + 1);
   localparam int CMP_W = (CAP_W > OCC_W) ? CAP_W : OCC_W;

   logic               req_valid_ff;
   op_type             req_op_ff;
   logic [KEY_W-1:0]   req_key_ff;
   logic [VAL_W-1:0]   req_val_ff;
   logic [CAP_W-1:0]   cap_ff;
   logic [OCC_W-1:0]   occ_ff, occ_in;
   logic               rsp_strobe_ff;
   logic               rsp_found_ff, rsp_found_in;
   logic [VAL_W-1:0]   rsp_read_ff, rsp_read_in;
   logic               rsp_evicted_ff, rsp_evicted_in;
   logic [KEY_W-1:0]   rsp_evkey_ff, rsp_evkey_in;

   logic               accept;
   logic               clear;
   logic               is_put;
   logic [CMP_W-1:0]   eff_cap;
   logic               full;
   entry_ctl_type      ctl;

   logic [ENTRIES-1:0] match;
   logic [ENTRIES-1:0] valid;
   logic [AGE_W-1:0]   ages   [ENTRIES];
   logic [KEY_W-1:0]   keys   [ENTRIES];
   logic [VAL_W-1:0]   values [ENTRIES];
   logic               hit;
   logic [AGE_W-1:0]   hit_age;
   logic [VAL_W-1:0]   hit_value;
   logic [ENTRIES-1:0] ins_oh;
   logic [KEY_W-1:0]   victim_key;
   logic [AGE_W-1:0]   oldest_age;

   assign busy      = reset;
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;
   assign clear     = csr_valid && csr_ready;
   assign is_put    = (req_op_ff == OP_PUT);

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_op_ff  <= op_type'(req_opcode);
         req_key_ff <= req_lookup_key;
         req_val_ff <= req_store_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else if (clear) begin
         cap_ff <= csr_capacity;
      end
   end

   always_comb begin
      if (cap_ff == '0) begin
         eff_cap = CMP_W'(1);
      end else if (CMP_W'(cap_ff) > CMP_W'(ENTRIES)) begin
         eff_cap = CMP_W'(ENTRIES);
      end else begin
         eff_cap = CMP_W'(cap_ff);
      end
   end

   assign full       = CMP_W'(occ_ff) >= eff_cap;
   assign oldest_age = AGE_W'(occ_ff - 1'b1);

   assign ctl.act   = req_valid_ff && !clear;
   assign ctl.put   = is_put;
   assign ctl.hit   = hit;
   assign ctl.clear = clear;

   for (genvar i = 0; i < ENTRIES; i++) begin : g_entry
      lkv_entry #(
         .AGE_W (AGE_W)
      ) u_entry (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .sel_hit  (match[i]),
         .sel_ins  (ins_oh[i]),
         .hit_age  (hit_age),
         .key_in   (req_key_ff),
         .value_in (req_val_ff),
         .match    (match[i]),
         .valid    (valid[i]),
         .age      (ages[i]),
         .key      (keys[i]),
         .value    (values[i])
      );
   end

   lkv_pick #(
      .ENTRIES (ENTRIES),
      .AGE_W   (AGE_W)
   ) u_pick (
      .match      (match),
      .valid      (valid),
      .ages       (ages),
      .keys       (keys),
      .values     (values),
      .oldest_age (oldest_age),
      .full       (full),
      .hit        (hit),
      .hit_age    (hit_age),
      .hit_value  (hit_value),
      .ins_oh     (ins_oh),
      .victim_key (victim_key)
   );

   always_comb begin
      occ_in         = occ_ff;
      rsp_found_in   = hit;
      rsp_read_in    = READ_MISS;
      rsp_evicted_in = 1'b0;
      rsp_evkey_in   = '0;
      if (hit) begin
         if (!is_put) begin
            rsp_read_in = hit_value;
         end
      end else if (is_put) begin
         if (full) begin
            rsp_evicted_in = 1'b1;
            rsp_evkey_in   = victim_key;
         end else begin
            occ_in = occ_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         occ_ff <= '0;
      end else if (req_valid_ff) begin
         occ_ff <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid_ff) begin
         rsp_found_ff   <= rsp_found_in;
         rsp_read_ff    <= rsp_read_in;
         rsp_evicted_ff <= rsp_evicted_in;
         rsp_evkey_ff   <= rsp_evkey_in;
      end
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_read_value  = rsp_read_ff;
   assign rsp_evicted     = rsp_evicted_ff;
   assign rsp_evicted_key = rsp_evkey_ff;

endmodule

`default_nettype wire

// ===== rtl/core/lkv_checker.sv =====
`default_nettype none

`include "lru_key_value_cache_macros.svh"

module lkv_checker
   import lkv_pkg::*;
(
   input wire logic                    clock,
   input wire logic                    reset,
   input wire logic                    start,
   input wire logic                    busy,
   input wire logic                    rsp_strobe,
   input wire logic                    rsp_found,
   input wire logic signed [VAL_W-1:0] rsp_read_value,
   input wire logic                    rsp_evicted,
   input wire logic signed [KEY_W-1:0] rsp_evicted_key
);

   // every transaction answered by a response strobe
   `LKV_ASSERT_LAT2(a_rsp_follows, clock, reset, start && !busy, rsp_strobe, "missing response")

   // no response without a transaction
   `LKV_ASSERT_NOW(a_no_spurious, clock, reset, rsp_strobe, $past(start && !busy, 2), "extra response")

   `LKV_ASSERT_NOW(a_evict_miss, clock, reset, rsp_strobe && rsp_evicted, !rsp_found, "eviction on hit")

   `LKV_ASSERT_NOW(a_evkey_zero, clock, reset, rsp_strobe && !rsp_evicted, rsp_evicted_key == '0, "evicted key not zero")

   `LKV_ASSERT_NOW(a_miss_value, clock, reset, rsp_strobe && !rsp_found, rsp_read_value == READ_MISS, "miss value not -1")

endmodule

bind lru_key_value_cache lkv_checker u_lkv_checker (.*);

`default_nettype wire
